[src/calendar_date_offset_core_macros.svh]
// Assertion macros shared by the checker of the date offset core
`ifndef CALENDAR_DATE_OFFSET_CORE_MACROS_SVH
`define CALENDAR_DATE_OFFSET_CORE_MACROS_SVH

// Check a property at every rising edge outside reset
`define CDO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every rising edge, reset included
`define CDO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cdo_pkg.sv]
// Shared types, constants and calendar helpers for the date offset core
package cdo_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int YEAR_BITS_DEF  = 14;

    // Days in one four-year leap cycle
    localparam int CYCLE_DAYS = 1461;
    localparam int LEAP_YEARS = 4;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAYS_31 = 5'd31;
    localparam logic [4:0] DAYS_30 = 5'd30;
    localparam logic [4:0] DAYS_29 = 5'd29;
    localparam logic [4:0] DAYS_28 = 5'd28;
    localparam logic [4:0] DAY_FIRST = 5'd1;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } cdo_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } cdo_cmd_t;

    typedef struct packed {
        logic finished;
    } cdo_status_t;

    // Length of a month; leap is set when the year divides by four
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == MONTH_FEB)
        begin
            len = leap ? DAYS_29 : DAYS_28;
        end
        else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV)
        begin
            len = DAYS_30;
        end
        else
        begin
            len = DAYS_31;
        end
        return len;
    endfunction

endpackage

[src/calendar_date_offset_core.sv]
// Calendar date offset core: moves a date forward or backward by a day count
//
// Input channel (in_valid/in_ready) takes one word: opcode (0 add, 1 subtract),
// start_day, start_month, start_year and day_count. Output channel
// (out_valid/out_ready) returns one word per input: the result date,
// start_valid and year_saturated. An invalid start date comes back unchanged.
//
// After acceptance the stepping loop runs one iteration per clock: a four-year
// skip of 1461 days, a whole-month crossing, a saturating stop at a range end,
// or the final in-month move. Iterations stay near count/1461 plus at most
// about 50 month crossings, under 100 for a 16-bit count. A new word is
// accepted the cycle after the previous result is written to the output
// register, so one word is in work at a time.
//
// Reset clears the controller to idle with the output slot empty; in_ready is
// high straight after reset. While the receiver stalls, a finished result
// waits in the working registers until the output slot frees; the output word
// holds steady until taken.
module calendar_date_offset_core
    import cdo_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int YEAR_BITS  = YEAR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [4:0]            start_day,
    input  logic [3:0]            start_month,
    input  logic [YEAR_BITS-1:0]  start_year,
    input  logic [COUNT_BITS-1:0] day_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [4:0]            result_day,
    output logic [3:0]            result_month,
    output logic [YEAR_BITS-1:0]  result_year,
    output logic                  start_valid,
    output logic                  year_saturated
);

    cdo_cmd_t    cmd;
    cdo_status_t status;

    // Sequence the request
    cdo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Step the date
    cdo_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .YEAR_BITS  (YEAR_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (opcode),
        .start_day      (start_day),
        .start_month    (start_month),
        .start_year     (start_year),
        .day_count      (day_count),
        .result_day     (result_day),
        .result_month   (result_month),
        .result_year    (result_year),
        .start_valid    (start_valid),
        .year_saturated (year_saturated)
    );

endmodule

[src/cdo_datapath.sv]
// Date stepping datapath: working date, remaining count and result word registers
module cdo_datapath
    import cdo_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int YEAR_BITS  = YEAR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdo_cmd_t              cmd,
    output cdo_status_t           status,
    input  logic                  opcode,
    input  logic [4:0]            start_day,
    input  logic [3:0]            start_month,
    input  logic [YEAR_BITS-1:0]  start_year,
    input  logic [COUNT_BITS-1:0] day_count,
    output logic [4:0]            result_day,
    output logic [3:0]            result_month,
    output logic [YEAR_BITS-1:0]  result_year,
    output logic                  start_valid,
    output logic                  year_saturated
);

    // Compare width wide enough for both the count and the cycle length
    localparam int W = (COUNT_BITS > 11) ? COUNT_BITS : 11;
    localparam logic [W-1:0] CYCLE_W = W'(CYCLE_DAYS);
    localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
    localparam logic [YEAR_BITS-1:0] YEAR_STEP = YEAR_BITS'(LEAP_YEARS);
    localparam logic [YEAR_BITS-1:0] YEAR_SKIP_TOP = YEAR_MAX - YEAR_STEP;

    logic [4:0]            day_reg, day_next;
    logic [3:0]            month_reg, month_next;
    logic [YEAR_BITS-1:0]  year_reg, year_next;
    logic [COUNT_BITS-1:0] steps_reg, steps_next;
    logic                  back_reg, back_next;
    logic                  ok_reg, ok_next;
    logic                  sat_reg, sat_next;

    logic [4:0]            res_day_reg;
    logic [3:0]            res_month_reg;
    logic [YEAR_BITS-1:0]  res_year_reg;
    logic                  res_ok_reg;
    logic                  res_sat_reg;

    logic                  start_ok;
    logic [4:0]            len;
    logic [4:0]            gap;
    logic [W-1:0]          steps_w;
    logic [3:0]            prev_month;
    logic [YEAR_BITS-1:0]  prev_year;

    // Check the start date
    always_comb
    begin
        start_ok = (start_month >= MONTH_JAN) && (start_month <= MONTH_DEC) &&
                   (start_day != 5'd0) &&
                   (start_day <= month_len(start_month, start_year[1:0] == 2'b00));
    end

    // Load or step: skip four years, finish in month, saturate or cross a month
    always_comb
    begin
        len        = month_len(month_reg, year_reg[1:0] == 2'b00);
        gap        = len - day_reg;
        steps_w    = W'(steps_reg);
        prev_month = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - 4'd1;
        prev_year  = (month_reg == MONTH_JAN) ? year_reg - YEAR_BITS'(1) : year_reg;

        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        steps_next = steps_reg;
        back_next  = back_reg;
        ok_next    = ok_reg;
        sat_next   = sat_reg;

        if (cmd.load)
        begin
            day_next   = start_day;
            month_next = start_month;
            year_next  = start_year;
            steps_next = start_ok ? day_count : '0;
            back_next  = opcode;
            ok_next    = start_ok;
            sat_next   = 1'b0;
        end
        else if (cmd.step && (steps_reg != '0))
        begin
            if (back_reg == OP_ADD)
            begin
                if ((steps_w >= CYCLE_W) && (year_reg <= YEAR_SKIP_TOP))
                begin
                    steps_next = COUNT_BITS'(steps_w - CYCLE_W);
                    year_next  = year_reg + YEAR_STEP;
                end
                else if (steps_w <= W'(gap))
                begin
                    day_next   = day_reg + steps_w[4:0];
                    steps_next = '0;
                end
                else if ((month_reg == MONTH_DEC) && (year_reg == YEAR_MAX))
                begin
                    day_next   = DAYS_31;
                    sat_next   = 1'b1;
                    steps_next = '0;
                end
                else
                begin
                    steps_next = COUNT_BITS'(steps_w - W'(gap) - W'(1));
                    day_next   = DAY_FIRST;
                    if (month_reg == MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + YEAR_BITS'(1);
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            else
            begin
                if ((steps_w >= CYCLE_W) && (year_reg >= YEAR_STEP))
                begin
                    steps_next = COUNT_BITS'(steps_w - CYCLE_W);
                    year_next  = year_reg - YEAR_STEP;
                end
                else if (steps_w < W'(day_reg))
                begin
                    day_next   = day_reg - steps_w[4:0];
                    steps_next = '0;
                end
                else if ((month_reg == MONTH_JAN) && (year_reg == '0))
                begin
                    day_next   = DAY_FIRST;
                    sat_next   = 1'b1;
                    steps_next = '0;
                end
                else
                begin
                    steps_next = COUNT_BITS'(steps_w - W'(day_reg));
                    month_next = prev_month;
                    year_next  = prev_year;
                    day_next   = month_len(prev_month, prev_year[1:0] == 2'b00);
                end
            end
        end
    end

    // Hold the working date and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= DAY_FIRST;
            month_reg <= MONTH_JAN;
            year_reg  <= '0;
            steps_reg <= '0;
            back_reg  <= OP_ADD;
            ok_reg    <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            steps_reg <= steps_next;
            back_reg  <= back_next;
            ok_reg    <= ok_next;
            sat_reg   <= sat_next;
        end
    end

    // Latch the finished date into the result word
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_day_reg   <= day_reg;
            res_month_reg <= month_reg;
            res_year_reg  <= year_reg;
            res_ok_reg    <= ok_reg;
            res_sat_reg   <= sat_reg;
        end
    end

    assign status.finished = (steps_reg == '0);
    assign result_day      = res_day_reg;
    assign result_month    = res_month_reg;
    assign result_year     = res_year_reg;
    assign start_valid     = res_ok_reg;
    assign year_saturated  = res_sat_reg;

endmodule

[src/cdo_ctrl.sv]
// Controller: input acceptance, stepping sequence and result word hand-off
module cdo_ctrl
    import cdo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output cdo_cmd_t    cmd,
    input  cdo_status_t status
);

    cdo_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step   = 1'b1;
                cmd.commit = status.finished && slot_free;
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Fill the result slot on commit, drop it when taken
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[src/cdo_checker.sv]
// Port-level checker for the date offset core and its bind
`include "calendar_date_offset_core_macros.svh"

module cdo_checker
    import cdo_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [4:0]           result_day,
    input logic [3:0]           result_month,
    input logic [YEAR_BITS-1:0] result_year,
    input logic                 start_valid,
    input logic                 year_saturated
);

    // A stalled result word must hold
    property p_out_hold;
        out_valid && !out_ready |=> out_valid && $stable(result_day) &&
            $stable(result_month) && $stable(result_year) &&
            $stable(start_valid) && $stable(year_saturated);
    endproperty

    // An invalid start date never saturates
    property p_invalid_no_sat;
        out_valid && !start_valid |-> !year_saturated;
    endproperty

    // Saturation leaves the date at one of the two range ends
    property p_sat_bounds;
        out_valid && year_saturated |->
            (result_month == MONTH_DEC && result_day == DAYS_31 && (&result_year)) ||
            (result_month == MONTH_JAN && result_day == DAY_FIRST && result_year == '0);
    endproperty

    `CDO_ASSERT(a_out_hold, clk, rst_n, p_out_hold, "result word changed while stalled")

    `CDO_ASSERT(a_invalid_no_sat, clk, rst_n, p_invalid_no_sat, "saturation on invalid date")

    `CDO_ASSERT(a_sat_bounds, clk, rst_n, p_sat_bounds, "saturated date not at a range end")

    // Result slot empty once a reset edge has passed
    `CDO_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind calendar_date_offset_core cdo_checker #(
    .YEAR_BITS (YEAR_BITS)
) u_cdo_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_day     (result_day),
    .result_month   (result_month),
    .result_year    (result_year),
    .start_valid    (start_valid),
    .year_saturated (year_saturated)
);

[tb/sv/cdo_date_scoreboard_pkg.sv]
// Scoreboard class holding the date offset predictor and the queue of expected result words
package cdo_date_scoreboard_pkg;
    import cdo_pkg::*;

    localparam int YEAR_W   = YEAR_BITS_DEF;
    localparam int COUNT_W  = COUNT_BITS_DEF;
    localparam int YEAR_TOP = (1 << YEAR_W) - 1;

    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
        logic              valid;
        logic              sat;
    } date_result_t;

    class date_offset_scoreboard;
        date_result_t pending_dates[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Four-year leap rule: every year divisible by four has a long February
        function int days_in_month(int month, int year);
            if (month == int'(MONTH_FEB))
            begin
                return (year % LEAP_YEARS == 0) ? int'(DAYS_29) : int'(DAYS_28);
            end
            if (month == int'(MONTH_APR) || month == int'(MONTH_JUN) ||
                month == int'(MONTH_SEP) || month == int'(MONTH_NOV))
            begin
                return int'(DAYS_30);
            end
            return int'(DAYS_31);
        endfunction

        function bit date_is_real(int day, int month, int year);
            if (month < int'(MONTH_JAN) || month > int'(MONTH_DEC) || day < int'(DAY_FIRST))
            begin
                return 1'b0;
            end
            return day <= days_in_month(month, year);
        endfunction

        // Move a date by a day count, skipping whole leap cycles and months
        function date_result_t shift_date(logic op, logic [4:0] day, logic [3:0] month,
                                          logic [YEAR_W-1:0] year, logic [COUNT_W-1:0] count);
            date_result_t res;
            int d;
            int m;
            int y;
            int left;
            int len;
            d = int'(day);
            m = int'(month);
            y = int'(year);
            left = int'(count);
            res.sat = 1'b0;
            res.valid = date_is_real(d, m, y);
            // drop the count for a date that does not exist
            if (!res.valid)
            begin
                left = 0;
            end
            while (left != 0)
            begin
                len = days_in_month(m, y);
                if (op == OP_ADD)
                begin
                    if (left >= CYCLE_DAYS && y + LEAP_YEARS <= YEAR_TOP)
                    begin
                        left -= CYCLE_DAYS;
                        y += LEAP_YEARS;
                    end
                    else if (left <= len - d)
                    begin
                        d += left;
                        left = 0;
                    end
                    else if (m == int'(MONTH_DEC) && y == YEAR_TOP)
                    begin
                        // hold at the last day of the top year
                        d = int'(DAYS_31);
                        res.sat = 1'b1;
                        left = 0;
                    end
                    else
                    begin
                        left -= len - d + 1;
                        d = int'(DAY_FIRST);
                        if (m == int'(MONTH_DEC))
                        begin
                            m = int'(MONTH_JAN);
                            y++;
                        end
                        else
                        begin
                            m++;
                        end
                    end
                end
                else
                begin
                    if (left >= CYCLE_DAYS && y >= LEAP_YEARS)
                    begin
                        left -= CYCLE_DAYS;
                        y -= LEAP_YEARS;
                    end
                    else if (left < d)
                    begin
                        d -= left;
                        left = 0;
                    end
                    else if (m == int'(MONTH_JAN) && y == 0)
                    begin
                        // hold at the first day of year zero
                        d = int'(DAY_FIRST);
                        res.sat = 1'b1;
                        left = 0;
                    end
                    else
                    begin
                        left -= d;
                        if (m == int'(MONTH_JAN))
                        begin
                            m = int'(MONTH_DEC);
                            y--;
                        end
                        else
                        begin
                            m--;
                        end
                        d = days_in_month(m, y);
                    end
                end
            end
            res.day = 5'(d);
            res.month = 4'(m);
            res.year = YEAR_W'(y);
            return res;
        endfunction

        function void note_request(logic op, logic [4:0] day, logic [3:0] month,
                                   logic [YEAR_W-1:0] year, logic [COUNT_W-1:0] count);
            pending_dates.push_back(shift_date(op, day, month, year, count));
        endfunction

        // Compare one result word against the oldest expected one
        function void check_result(date_result_t got);
            date_result_t want;
            if (pending_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result word %0d/%0d/%0d with nothing expected",
                             got.day, got.month, got.year);
                end
                return;
            end
            want = pending_dates.pop_front();
            if (got.day !== want.day || got.month !== want.month || got.year !== want.year ||
                got.valid !== want.valid || got.sat !== want.sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: expected %0d/%0d/%0d valid=%b sat=%b, got %0d/%0d/%0d valid=%b sat=%b",
                             want.day, want.month, want.year, want.valid, want.sat,
                             got.day, got.month, got.year, got.valid, got.sat);
                end
            end
        endfunction
    endclass

endpackage

[tb/sv/tb_calendar_date_offset_core.sv]
// Testbench top for the calendar date offset core: directed and random requests, scoreboard check
module tb_calendar_date_offset_core;
    import cdo_pkg::*;
    import cdo_date_scoreboard_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 247;
    localparam int HOLD_OFF_AT     = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 120;
    localparam int CYCLE_LIMIT     = 2000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               opcode = OP_ADD;
    logic [4:0]         start_day = '0;
    logic [3:0]         start_month = '0;
    logic [YEAR_W-1:0]  start_year = '0;
    logic [COUNT_W-1:0] day_count = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [4:0]         result_day;
    logic [3:0]         result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               start_valid;
    logic               year_saturated;

    date_offset_scoreboard board = new();
    int cycle_count = 0;
    int results_taken = 0;

    calendar_date_offset_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .start_day      (start_day),
        .start_month    (start_month),
        .start_year     (start_year),
        .day_count      (day_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_day     (result_day),
        .result_month   (result_month),
        .result_year    (result_year),
        .start_valid    (start_valid),
        .year_saturated (year_saturated)
    );

    always #4 clk = ~clk;

    // Offer one request word after a random gap and hold it until taken
    task automatic send_request(logic op, logic [4:0] day, logic [3:0] month,
                                logic [YEAR_W-1:0] year, logic [COUNT_W-1:0] count);
        int gap;
        gap = int'($urandom_range(0, 3));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        start_day   <= day;
        start_month <= month;
        start_year  <= year;
        day_count   <= count;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        board.note_request(op, day, month, year, count);
    endtask

    // Mostly real dates, many near the ends of the year range or on month ends, some raw noise
    task automatic send_random_request();
        logic               op;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
        int                 pick;
        int                 len;
        op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
        begin
            day   = 5'($urandom);
            month = 4'($urandom);
            year  = YEAR_W'($urandom);
            count = COUNT_W'($urandom);
        end
        else
        begin
            pick = int'($urandom_range(0, 9));
            if (pick < 3)
            begin
                year = YEAR_W'($urandom_range(0, 9));
            end
            else if (pick < 6)
            begin
                year = YEAR_W'(YEAR_TOP - int'($urandom_range(0, 9)));
            end
            else
            begin
                year = YEAR_W'($urandom_range(0, YEAR_TOP));
            end
            month = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
            len = board.days_in_month(int'(month), int'(year));
            day = ($urandom_range(0, 3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
            pick = int'($urandom_range(0, 9));
            if (pick < 3)
            begin
                count = COUNT_W'($urandom_range(0, 40));
            end
            else if (pick < 5)
            begin
                count = COUNT_W'($urandom_range(0, 1500));
            end
            else if (pick < 6)
            begin
                count = COUNT_W'($urandom_range(0, 400));
            end
            else if (pick < 9)
            begin
                count = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
            end
            else
            begin
                count = COUNT_W'((1 << COUNT_W) - 1 - int'($urandom_range(0, 10)));
            end
        end
        send_request(op, day, month, year, count);
    endtask

    // Reset, directed words, random words, then drain and give the verdict
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero count, all-zero and all-ones words
        send_request(OP_ADD, 5'd15, 4'd6, 14'd2000, 16'd0);
        send_request(OP_ADD, 5'd0, 4'd0, 14'd0, 16'd0);
        send_request(OP_SUB, 5'd31, 4'd15, YEAR_W'(YEAR_TOP), 16'hFFFF);
        // largest counts from both ends of the range
        send_request(OP_ADD, 5'd1, MONTH_JAN, 14'd0, 16'hFFFF);
        send_request(OP_SUB, 5'd31, MONTH_DEC, YEAR_W'(YEAR_TOP), 16'hFFFF);
        // saturation at the top and at year zero
        send_request(OP_ADD, 5'd31, MONTH_DEC, YEAR_W'(YEAR_TOP), 16'd1);
        send_request(OP_SUB, 5'd1, MONTH_JAN, 14'd0, 16'd1);
        send_request(OP_ADD, 5'd1, MONTH_JAN, YEAR_W'(YEAR_TOP - 3), 16'd2000);
        send_request(OP_SUB, 5'd1, MONTH_JAN, 14'd3, 16'd1461);
        // dates that do not exist
        send_request(OP_ADD, 5'd0, 4'd5, 14'd2001, 16'd10);
        send_request(OP_ADD, 5'd10, 4'd0, 14'd2001, 16'd10);
        send_request(OP_SUB, 5'd10, 4'd13, 14'd2001, 16'd10);
        send_request(OP_ADD, 5'd31, MONTH_APR, 14'd2001, 16'd3);
        send_request(OP_ADD, 5'd29, MONTH_FEB, 14'd2001, 16'd1);
        send_request(OP_SUB, 5'd30, MONTH_FEB, 14'd2004, 16'd1);
        // leap day and month ends in both directions
        send_request(OP_ADD, 5'd29, MONTH_FEB, 14'd2004, 16'd1);
        send_request(OP_ADD, 5'd28, MONTH_FEB, 14'd2003, 16'd1);
        send_request(OP_SUB, 5'd1, 4'd3, 14'd2004, 16'd1);
        send_request(OP_SUB, 5'd1, 4'd3, 14'd2003, 16'd1);
        send_request(OP_ADD, 5'd31, MONTH_DEC, 14'd1999, 16'd1);
        send_request(OP_SUB, 5'd1, MONTH_JAN, 14'd2000, 16'd1);
        send_request(OP_ADD, 5'd30, MONTH_NOV, 14'd7, 16'd1461);
        send_request(OP_SUB, 5'd15, 4'd7, 14'd4, 16'd1461);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_random_request();
        end
        in_valid <= 1'b0;

        // wait for every expected word, then watch for stray ones
        while (board.pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_dates.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Take result words after random stalls, with one long hold-off to back the block up
    initial
    begin
        int stall;
        date_result_t got;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (results_taken == HOLD_OFF_AT)
            begin
                stall = HOLD_OFF_CYCLES;
            end
            else
            begin
                stall = int'($urandom_range(0, 3));
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            got.day   = result_day;
            got.month = result_month;
            got.year  = result_year;
            got.valid = start_valid;
            got.sat   = year_saturated;
            board.check_result(got);
            results_taken++;
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/cdo_pkg.sv
src/cdo_datapath.sv
src/cdo_ctrl.sv
src/calendar_date_offset_core.sv
src/cdo_checker.sv
tb/sv/cdo_date_scoreboard_pkg.sv
tb/sv/tb_calendar_date_offset_core.sv
